@@ rtl/core/dbcs_aware_token_splitter_assert.svh @@
// ----------------------------------------------------------------------------
// DBCS token splitter assertion macros
// Concurrent assertion helpers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DBCS_AWARE_TOKEN_SPLITTER_ASSERT_SVH
`define DBCS_AWARE_TOKEN_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DBCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dbcs: same-cycle assertion failed");
`define DBCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dbcs: next-cycle assertion failed");
`else
`define DBCS_ASSERT_SAME(label, ante, cons)
`define DBCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/dbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// DBCS token splitter package
// Shared constants, register codes and inter-module structures.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcs_pkg;

    localparam int DELIM_SLOTS = 4;
    localparam int INDEX_WIDTH = 16;
    localparam int POS_W       = 16;
    localparam int LEN_W       = 16;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_DELIM_REGS = 4;
    localparam int CMP_W = (INDEX_WIDTH > LEN_W) ? INDEX_WIDTH : LEN_W;

    localparam logic [7:0] DB_LOW = 8'h81;
    localparam logic [7:0] DB_END = 8'hFF;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;
    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_C     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BYTE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 3'd6;

    typedef struct packed {
        logic [DELIM_SLOTS-1:0][7:0] delim;
        logic [CNT_W-1:0]            delim_count;
        logic                        double_byte_mode;
        logic [LEN_W-1:0]            max_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic             copied;
        logic             at_stop;
        logic             end_reached;
        logic [POS_W-1:0] position;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/core/dbcs_cfg.sv @@
// ----------------------------------------------------------------------------
// DBCS token splitter configuration registers
// Holds the delimiter set, mode bit and length limit written by the host.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcs_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dbcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dbcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dbcs_pkg::t_cfg                        o_cfg
);

    dbcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim            <= '0;
            r_cfg.delim_count      <= '0;
            r_cfg.double_byte_mode <= 1'b0;
            r_cfg.max_len          <= dbcs_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            for (int k = 0; k < dbcs_pkg::DELIM_SLOTS; k++) begin
                if (k < dbcs_pkg::CFG_DELIM_REGS &&
                    i_cfg_index == dbcs_pkg::CFG_IDX_W'(int'(dbcs_pkg::CFG_DELIM_A) + k)) begin
                    r_cfg.delim[k] <= i_cfg_data[7:0];
                end
            end
            case (i_cfg_index)
                dbcs_pkg::CFG_DELIM_COUNT: begin
                    r_cfg.delim_count <= i_cfg_data[dbcs_pkg::CNT_W-1:0];
                end
                dbcs_pkg::CFG_DOUBLE_BYTE: begin
                    r_cfg.double_byte_mode <= i_cfg_data[0];
                end
                dbcs_pkg::CFG_MAX_LEN: begin
                    r_cfg.max_len <= i_cfg_data[dbcs_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/dbcs_scan.sv @@
// ----------------------------------------------------------------------------
// DBCS token splitter byte scanner
// Decides per byte whether it is copied or stops the token, and keeps the
// lead-byte parity, byte index and stopped flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dbcs_aware_token_splitter_assert.svh"

module dbcs_scan (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last,
    input  wire dbcs_pkg::t_cfg i_cfg,
    output logic             o_res_valid,
    output dbcs_pkg::t_res   o_res
);

    logic                               r_parity;
    logic [dbcs_pkg::INDEX_WIDTH-1:0]   r_index;
    logic                               r_stopped;
    logic                               n_parity;
    logic [dbcs_pkg::INDEX_WIDTH-1:0]   n_index;
    logic                               n_stopped;

    logic                               delim_hit;
    logic                               masked;
    logic                               stop;
    logic                               is_db;
    logic [dbcs_pkg::LEN_W-1:0]         limit;
    logic [dbcs_pkg::CMP_W-1:0]         idx_ext;
    logic [dbcs_pkg::CMP_W-1:0]         lim_ext;

    always_comb begin
        delim_hit = 1'b0;
        for (int k = 0; k < dbcs_pkg::DELIM_SLOTS; k++) begin
            if (k < int'(i_cfg.delim_count) && i_cfg.delim[k] != 8'h00 &&
                i_cfg.delim[k] == i_in_byte) begin
                delim_hit = 1'b1;
            end
        end
    end

    always_comb begin
        limit   = (i_cfg.max_len == '0) ? '0 : i_cfg.max_len - dbcs_pkg::LEN_W'(1);
        idx_ext = dbcs_pkg::CMP_W'(r_index);
        lim_ext = dbcs_pkg::CMP_W'(limit);
        masked  = i_cfg.double_byte_mode && (r_index != '0) && r_parity;
        stop    = (delim_hit && !masked) || (idx_ext >= lim_ext);
        is_db   = (i_in_byte >= dbcs_pkg::DB_LOW) && (i_in_byte < dbcs_pkg::DB_END);

        o_res_valid       = !r_stopped;
        o_res.byte_out    = i_in_byte;
        o_res.copied      = !stop;
        o_res.at_stop     = stop;
        o_res.end_reached = i_last;
        o_res.position    = (idx_ext > dbcs_pkg::CMP_W'(dbcs_pkg::POS_MAX)) ?
                            dbcs_pkg::POS_MAX : idx_ext[dbcs_pkg::POS_W-1:0];
    end

    always_comb begin
        n_parity  = is_db ? !r_parity : 1'b0;
        n_index   = r_index;
        n_stopped = r_stopped;
        if (!r_stopped) begin
            if (stop) begin
                n_stopped = 1'b1;
            end
            if (r_index != dbcs_pkg::INDEX_MAX) begin
                n_index = r_index + dbcs_pkg::INDEX_WIDTH'(1);
            end
        end
        if (i_last) begin
            n_parity  = 1'b0;
            n_index   = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity  <= 1'b0;
            r_index   <= '0;
            r_stopped <= 1'b0;
        end else if (i_acc) begin
            r_parity  <= n_parity;
            r_index   <= n_index;
            r_stopped <= n_stopped;
        end
    end

    `DBCS_ASSERT_NEXT(a_stop_sticks, i_acc && !r_stopped && stop && !i_last, r_stopped)
    `DBCS_ASSERT_NEXT(a_last_clears, i_acc && i_last, r_index == '0 && !r_stopped && !r_parity)
    `DBCS_ASSERT_NEXT(a_index_steps,
        i_acc && !r_stopped && !i_last && r_index != dbcs_pkg::INDEX_MAX,
        r_index == $past(r_index) + dbcs_pkg::INDEX_WIDTH'(1))

endmodule

`default_nettype wire

@@ rtl/core/dbcs_outreg.sv @@
// ----------------------------------------------------------------------------
// DBCS token splitter result register
// Holds one result beat and parts the input handshake from the output one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dbcs_aware_token_splitter_assert.svh"

module dbcs_outreg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_res_valid,
    input  wire dbcs_pkg::t_res i_res,
    input  wire logic        i_out_stall,
    output logic             o_in_stall,
    output logic             o_acc,
    output logic             o_out_valid,
    output dbcs_pkg::t_res   o_res
);

    logic           r_valid;
    logic           n_valid;
    dbcs_pkg::t_res r_res;

    assign o_in_stall = r_valid && i_out_stall;
    assign o_acc      = i_in_valid && !o_in_stall;
    assign n_valid    = o_acc && i_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    `DBCS_ASSERT_NEXT(a_result_loaded, n_valid, r_valid && r_res == $past(i_res))

endmodule

`default_nettype wire

@@ rtl/core/dbcs_aware_token_splitter.sv @@
// Each beat is registered and shown the cycle after its byte is accepted.
// Throughput: one byte per cycle while not stalled; scan state is registered.
// The input stalls only while the result register is full and stalled.
// Synchronous active-low reset clears the scan state and result valid flag and
// restores the configuration defaults (no delimiters, length limit 256).
// ----------------------------------------------------------------------------
// DBCS-aware token splitter
// Splits the first token off a byte stream, honouring double-byte trail bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcs_aware_token_splitter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dbcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dbcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [7:0]                       i_in_byte,
    input  wire logic                             i_last,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [7:0]                            o_byte_out,
    output logic                                  o_copied,
    output logic                                  o_at_stop,
    output logic                                  o_end_reached,
    output logic [dbcs_pkg::POS_W-1:0]            o_position
);

    dbcs_pkg::t_cfg cfg;
    dbcs_pkg::t_res scan_res;
    dbcs_pkg::t_res out_res;
    logic           scan_valid;
    logic           acc;

    dbcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dbcs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_in_byte   (i_in_byte),
        .i_last      (i_last),
        .i_cfg       (cfg),
        .o_res_valid (scan_valid),
        .o_res       (scan_res)
    );

    dbcs_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_res_valid (scan_valid),
        .i_res       (scan_res),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_acc       (acc),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_byte_out    = out_res.byte_out;
    assign o_copied      = out_res.copied;
    assign o_at_stop     = out_res.at_stop;
    assign o_end_reached = out_res.end_reached;
    assign o_position    = out_res.position;

endmodule

`default_nettype wire
